[design/character_class_tokenizer_top_defines.svh]
// assertion macros for the tokenizer
`ifndef CHARACTER_CLASS_TOKENIZER_TOP_DEFINES_SVH
`define CHARACTER_CLASS_TOKENIZER_TOP_DEFINES_SVH

`ifndef SYNTH

// cond must hold at every edge out of reset
`define CCT_ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("tokenizer assertion failed");

// cons must hold in the cycle after ante
`define CCT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tokenizer assertion failed");

`else

`define CCT_ASSERT_ALWAYS(lbl, clk, rst_n, cond)
`define CCT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

[design/cct_pkg.sv]
package cct_pkg;

    // result queue
    localparam int unsigned QDEPTH = 4;
    localparam int unsigned QPTR_W = $clog2(QDEPTH);
    localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

    localparam logic [7:0] QUOTE_CH = 8'h27;
    localparam logic [7:0] DOT_CH   = 8'h2E;

    localparam logic [2:0] MODE_IDLE   = 3'd0;
    localparam logic [2:0] MODE_STRING = 3'd1;
    localparam logic [2:0] MODE_NUMBER = 3'd2;
    localparam logic [2:0] MODE_WORD   = 3'd3;
    localparam logic [2:0] MODE_DROP   = 3'd4;

    localparam logic [1:0] KIND_STRING = 2'd0;
    localparam logic [1:0] KIND_PUNCT  = 2'd1;
    localparam logic [1:0] KIND_NUMBER = 2'd2;
    localparam logic [1:0] KIND_WORD   = 2'd3;

    localparam logic [1:0] ERR_NONE    = 2'd0;
    localparam logic [1:0] ERR_INVALID = 2'd1;
    localparam logic [1:0] ERR_UNTERM  = 2'd2;

    typedef struct packed {
        logic       has_char;
        logic [7:0] char_out;
        logic [1:0] token_kind;
        logic       token_start;
        logic [1:0] error_code;
        logic       stream_end;
        logic       run_last;
    } t_result;

    // results caused by one input beat, in order
    typedef struct packed {
        logic [1:0]    cnt;
        t_result [1:0] res;
    } t_step;

    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
    endfunction

    function automatic logic is_punct(input logic [7:0] c);
        return c >= 8'd33 && c <= 8'd126 && !is_digit(c) && !is_alpha(c);
    endfunction

    function automatic t_result mk_res(input logic has, input logic [7:0] ch,
                                       input logic [1:0] kind, input logic start,
                                       input logic [1:0] err);
        t_result r;
        r.has_char    = has;
        r.char_out    = ch;
        r.token_kind  = kind;
        r.token_start = start;
        r.error_code  = err;
        r.stream_end  = 1'b0;
        r.run_last    = 1'b0;
        return r;
    endfunction

endpackage

[design/cct_in_if.sv]
interface cct_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_char;
    logic       in_last;

    modport source (output valid, output in_char, output in_last, input ready);
    modport sink   (input valid, input in_char, input in_last, output ready);
endinterface

[design/cct_out_if.sv]
interface cct_out_if;
    logic       valid;
    logic       ready;
    logic       has_char;
    logic [7:0] char_out;
    logic [1:0] token_kind;
    logic       token_start;
    logic [1:0] error_code;
    logic       stream_end;
    logic       run_last;

    modport source (output valid, output has_char, output char_out, output token_kind,
                    output token_start, output error_code, output stream_end,
                    output run_last, input ready);
    modport sink   (input valid, input has_char, input char_out, input token_kind,
                    input token_start, input error_code, input stream_end,
                    input run_last, output ready);
endinterface

[design/character_class_tokenizer_top.sv]
// character class tokenizer
// i_in carries one text byte per beat (in_char) with in_last on the final
// byte. o_out carries result beats: a token character tagged with its kind
// and a start-of-token mark, or an error or empty closing result. run_last
// marks the last result of an input byte, stream_end the one closing the text.
// a byte yields zero, one or two results; the scan state is updated and the
// results written into a 4-entry result queue at the accepting edge, and o_out
// is driven straight from the head of that queue.
// throughput is one byte per cycle while i_in.ready holds; a byte yielding
// two results holds the output for two beats, which the queue absorbs while
// bytes keep coming. the rate is set by the single output port of the queue.
// i_in.ready stays high while at least two queue entries are free, so a
// stalled receiver lets the queue fill and input stops while fewer are free.
// reset (synchronous, active low) clears the scan mode, the held dot and
// the queue; nothing else needs clearing.
`include "character_class_tokenizer_top_defines.svh"

module character_class_tokenizer_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    cct_in_if.sink     i_in,
    cct_out_if.source  o_out
);

    localparam int unsigned QPTR_W = cct_pkg::QPTR_W;
    localparam int unsigned QCNT_W = cct_pkg::QCNT_W;

    cct_pkg::t_step   step;
    cct_pkg::t_result r_q [cct_pkg::QDEPTH];
    cct_pkg::t_result head;
    logic [QPTR_W-1:0] r_wr;
    logic [QPTR_W-1:0] r_rd;
    logic [QCNT_W-1:0] r_cnt;
    logic accept;
    logic pop;

    assign accept = i_in.valid && i_in.ready;
    assign pop    = o_out.valid && o_out.ready;

    cct_scan u_scan (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_char   (i_in.in_char),
        .i_last   (i_in.in_last),
        .o_step   (step)
    );

    assign i_in.ready  = r_cnt <= QCNT_W'(cct_pkg::QDEPTH - 2);
    assign o_out.valid = r_cnt != '0;

    assign head              = r_q[r_rd];
    assign o_out.has_char    = head.has_char;
    assign o_out.char_out    = head.char_out;
    assign o_out.token_kind  = head.token_kind;
    assign o_out.token_start = head.token_start;
    assign o_out.error_code  = head.error_code;
    assign o_out.stream_end  = head.stream_end;
    assign o_out.run_last    = head.run_last;

    always_ff @(posedge i_clk) begin
        if (accept && step.cnt != 2'd0) r_q[r_wr] <= step.res[0];
        if (accept && step.cnt == 2'd2) r_q[r_wr + QPTR_W'(1)] <= step.res[1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (accept) r_wr <= r_wr + QPTR_W'(step.cnt);
            if (pop)    r_rd <= r_rd + QPTR_W'(1);
            r_cnt <= r_cnt + (accept ? QCNT_W'(step.cnt) : QCNT_W'(0))
                           - QCNT_W'(pop);
        end
    end

    `CCT_ASSERT_ALWAYS(a_q_bound, i_clk, i_rst_n, r_cnt <= QCNT_W'(cct_pkg::QDEPTH))
    `CCT_ASSERT_ALWAYS(a_last_has_result, i_clk, i_rst_n, !(accept && i_in.in_last) || step.cnt != 2'd0)
    `CCT_ASSERT_ALWAYS(a_end_closes_run, i_clk, i_rst_n, !(pop && o_out.stream_end) || o_out.run_last)
    `CCT_ASSERT_NEXT(a_push_visible, i_clk, i_rst_n, accept && step.cnt != 2'd0 && r_cnt == '0, o_out.valid)

endmodule

[design/cct_scan.sv]
module cct_scan (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_accept,
    input  logic [7:0]    i_char,
    input  logic          i_last,
    output cct_pkg::t_step o_step
);

    logic [2:0] r_mode;
    logic       r_held;
    logic [2:0] n_mode;
    logic       n_held;
    cct_pkg::t_step s;
    logic       do_idle;

    function automatic void push(inout cct_pkg::t_step st, input cct_pkg::t_result r);
        if (st.cnt < 2'd2) begin
            st.res[st.cnt[0]] = r;
            st.cnt = st.cnt + 2'd1;
        end
    endfunction

    always_comb begin
        s       = '0;
        n_mode  = r_mode;
        n_held  = r_held;
        do_idle = 1'b0;

        case (r_mode)
            cct_pkg::MODE_STRING: begin
                push(s, cct_pkg::mk_res(1'b1, i_char, cct_pkg::KIND_STRING, 1'b0,
                                        cct_pkg::ERR_NONE));
                if (i_char == cct_pkg::QUOTE_CH) n_mode = cct_pkg::MODE_IDLE;
            end
            cct_pkg::MODE_NUMBER: begin
                if (cct_pkg::is_digit(i_char)) begin
                    if (r_held) push(s, cct_pkg::mk_res(1'b1, cct_pkg::DOT_CH,
                        cct_pkg::KIND_NUMBER, 1'b0, cct_pkg::ERR_NONE));
                    n_held = 1'b0;
                    push(s, cct_pkg::mk_res(1'b1, i_char, cct_pkg::KIND_NUMBER, 1'b0,
                                            cct_pkg::ERR_NONE));
                end else if (i_char == cct_pkg::DOT_CH) begin
                    if (r_held) push(s, cct_pkg::mk_res(1'b1, cct_pkg::DOT_CH,
                        cct_pkg::KIND_NUMBER, 1'b0, cct_pkg::ERR_NONE));
                    n_held = 1'b1;
                end else begin
                    // held dot goes back out as its own punctuation token
                    if (r_held) push(s, cct_pkg::mk_res(1'b1, cct_pkg::DOT_CH,
                        cct_pkg::KIND_PUNCT, 1'b1, cct_pkg::ERR_NONE));
                    n_held  = 1'b0;
                    do_idle = 1'b1;
                end
            end
            cct_pkg::MODE_WORD: begin
                if (cct_pkg::is_alpha(i_char) || cct_pkg::is_digit(i_char))
                    push(s, cct_pkg::mk_res(1'b1, i_char, cct_pkg::KIND_WORD, 1'b0,
                                            cct_pkg::ERR_NONE));
                else
                    do_idle = 1'b1;
            end
            cct_pkg::MODE_DROP: begin
            end
            default: do_idle = 1'b1;
        endcase

        if (do_idle) begin
            n_mode = cct_pkg::MODE_IDLE;
            if (cct_pkg::is_space(i_char)) begin
            end else if (i_char == cct_pkg::QUOTE_CH) begin
                if (i_last) begin
                    push(s, cct_pkg::mk_res(1'b0, 8'd0, cct_pkg::KIND_STRING, 1'b0,
                                            cct_pkg::ERR_UNTERM));
                    n_mode = cct_pkg::MODE_DROP;
                end else begin
                    push(s, cct_pkg::mk_res(1'b1, i_char, cct_pkg::KIND_STRING, 1'b1,
                                            cct_pkg::ERR_NONE));
                    n_mode = cct_pkg::MODE_STRING;
                end
            end else if (cct_pkg::is_punct(i_char)) begin
                push(s, cct_pkg::mk_res(1'b1, i_char, cct_pkg::KIND_PUNCT, 1'b1,
                                        cct_pkg::ERR_NONE));
            end else if (cct_pkg::is_digit(i_char)) begin
                push(s, cct_pkg::mk_res(1'b1, i_char, cct_pkg::KIND_NUMBER, 1'b1,
                                        cct_pkg::ERR_NONE));
                n_mode = cct_pkg::MODE_NUMBER;
            end else if (cct_pkg::is_alpha(i_char)) begin
                push(s, cct_pkg::mk_res(1'b1, i_char, cct_pkg::KIND_WORD, 1'b1,
                                        cct_pkg::ERR_NONE));
                n_mode = cct_pkg::MODE_WORD;
            end else begin
                push(s, cct_pkg::mk_res(1'b0, 8'd0, cct_pkg::KIND_STRING, 1'b0,
                                        cct_pkg::ERR_INVALID));
                n_mode = cct_pkg::MODE_DROP;
            end
        end

        if (i_last) begin
            if (n_mode == cct_pkg::MODE_STRING)
                push(s, cct_pkg::mk_res(1'b0, 8'd0, cct_pkg::KIND_STRING, 1'b0,
                                        cct_pkg::ERR_UNTERM));
            if (n_held)
                push(s, cct_pkg::mk_res(1'b1, cct_pkg::DOT_CH, cct_pkg::KIND_PUNCT, 1'b1,
                                        cct_pkg::ERR_NONE));
            // final beat always closes with at least one result
            if (s.cnt == 2'd0)
                push(s, cct_pkg::mk_res(1'b0, 8'd0, cct_pkg::KIND_STRING, 1'b0,
                                        cct_pkg::ERR_NONE));
            s.res[s.cnt[0] ^ 1'b1].stream_end = 1'b1;
            n_mode = cct_pkg::MODE_IDLE;
            n_held = 1'b0;
        end

        if (s.cnt != 2'd0) s.res[s.cnt[0] ^ 1'b1].run_last = 1'b1;
    end

    // index cnt-1 above: cnt is 1 or 2, so low bit flipped picks slot 0 or 1
    assign o_step = s;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= cct_pkg::MODE_IDLE;
            r_held <= 1'b0;
        end else if (i_accept) begin
            r_mode <= n_mode;
            r_held <= n_held;
        end
    end

endmodule
